### rtl/dqr_pkg.sv
// dqr_pkg: shared types, codes and helpers for the dns query id remap table
// used by dqr_cell, dqr_ctrl and dns_query_id_remap_table_top; no dependencies
`default_nettype none

package dqr_pkg;

   // table size default and slot index width covering every legal table size
   localparam int TABLE_SLOTS_DEF = 64;
   localparam int IDX_W           = 10;

   localparam int ID_W    = 16;
   localparam int ADDR_W  = 48;
   localparam int STAMP_W = 32;

   // id generator
   localparam logic [ID_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [ID_W-1:0] LFSR_TAPS = 16'hB400;

   // request actions
   localparam logic [1:0] ACT_QUERY  = 2'd0;
   localparam logic [1:0] ACT_REPLY  = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;

   // retryable reply codes
   localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
   localparam logic [3:0] RCODE_NOTIMP   = 4'd4;
   localparam logic [3:0] RCODE_REFUSED  = 4'd5;

   // result status codes
   localparam logic [2:0] STAT_NEW       = 3'd0;
   localparam logic [2:0] STAT_RETRY     = 3'd1;
   localparam logic [2:0] STAT_EMPTY     = 3'd2;
   localparam logic [2:0] STAT_DELIVER   = 3'd3;
   localparam logic [2:0] STAT_RETRYABLE = 3'd4;
   localparam logic [2:0] STAT_NO_MATCH  = 3'd5;
   localparam logic [2:0] STAT_CANCELLED = 3'd6;

   // kind of pass a search packet makes through the cell row
   typedef enum logic [1:0] {
      MODE_QUERY  = 2'd0,   // client match, free slot, oldest slot, candidate check
      MODE_LOOKUP = 2'd1,   // match by upstream id
      MODE_CAND   = 2'd2    // candidate id check only
   } mode_type;

   // search packet handed from cell to cell
   typedef struct packed {
      logic                valid;
      mode_type            mode;
      logic [ID_W-1:0]     key_id;
      logic [ADDR_W-1:0]   key_addr;
      logic [ID_W-1:0]     cand;
      logic                hit;
      logic [IDX_W-1:0]    hit_idx;
      logic [ID_W-1:0]     hit_up;
      logic [ID_W-1:0]     hit_cid;
      logic [ADDR_W-1:0]   hit_addr;
      logic                free_found;
      logic [IDX_W-1:0]    free_idx;
      logic [IDX_W-1:0]    old_idx;
      logic [STAMP_W-1:0]  old_time;
      logic                cand_used;
   } pkt_type;

   // slot write broadcast to every cell
   typedef struct packed {
      logic                en;
      logic                clear;
      logic [IDX_W-1:0]    idx;
      logic [ID_W-1:0]     up;
      logic [ID_W-1:0]     cid;
      logic [ADDR_W-1:0]   addr;
      logic [STAMP_W-1:0]  stamp;
   } wr_type;

   // one step of the galois id generator
   function automatic logic [ID_W-1:0] lfsr_step(input logic [ID_W-1:0] x);
      logic [ID_W-1:0] y;
      y = x >> 1;
      if (x[0]) begin
         y = y ^ LFSR_TAPS;
      end
      return y;
   endfunction

endpackage

`default_nettype wire

### rtl/dns_query_id_remap_table_top.sv
// dns_query_id_remap_table_top: dns query id remap table, sequencer plus a row of slot cells
// depends on dqr_pkg, dqr_ctrl and dqr_cell
//
//   channel   ports                          handshake
//   request   start/busy, req_*              accepted when start high and busy low
//   result    rsp_valid, rsp_*               one-cycle strobe, always taken
//   config    csr_valid/csr_ready, csr_*     written when valid and ready high
//
// every slot is a cell; a search packet walks the row one cell per cycle, and a
// query, reply or cancel makes one pass of the row, plus one more pass per candidate
// upstream id already in use; empty answers and unused actions make no pass.
// reset clears all upstream ids at once; no clearing pass. the result side never stalls.
`default_nettype none

module dns_query_id_remap_table_top #(
   parameter int TABLE_SLOTS = dqr_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_packet_id,
   input  wire logic [47:0] req_client_addr,
   input  wire logic        req_recursion_desired,
   input  wire logic [3:0]  req_rcode,
   input  wire logic [31:0] req_now,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_upstream_present,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_upstream_id,
   output logic [15:0]      rsp_client_id,
   output logic [47:0]      rsp_client_addr_out,
   output logic [5:0]       rsp_slot,
   output logic             rsp_evicted
);

   dqr_pkg::pkt_type link [0:TABLE_SLOTS];
   dqr_pkg::wr_type  wr;

   // sequencer
   dqr_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_packet_id         (req_packet_id),
      .req_client_addr       (req_client_addr),
      .req_recursion_desired (req_recursion_desired),
      .req_rcode             (req_rcode),
      .req_now               (req_now),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_upstream_present  (csr_upstream_present),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_upstream_id       (rsp_upstream_id),
      .rsp_client_id         (rsp_client_id),
      .rsp_client_addr_out   (rsp_client_addr_out),
      .rsp_slot              (rsp_slot),
      .rsp_evicted           (rsp_evicted),
      .pkt_head              (link[0]),
      .pkt_tail              (link[TABLE_SLOTS]),
      .wr                    (wr)
   );

   // row of slot cells
   for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      dqr_cell #(
         .CELL_NUM (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .pkt_in  (link[g]),
         .pkt_out (link[g+1]),
         .wr      (wr)
      );
   end

endmodule

`default_nettype wire

### rtl/dqr_cell.sv
// dqr_cell: one table slot plus one stage of the search packet row
// depends on dqr_pkg (packet and write types)
`default_nettype none

module dqr_cell #(
   parameter int CELL_NUM = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dqr_pkg::pkt_type pkt_in,
   output dqr_pkg::pkt_type      pkt_out,
   input  wire dqr_pkg::wr_type  wr
);

   localparam logic [dqr_pkg::IDX_W-1:0] MY_IDX = dqr_pkg::IDX_W'(CELL_NUM);

   logic [dqr_pkg::ID_W-1:0]    up_ff;
   logic [dqr_pkg::ID_W-1:0]    cid_ff;
   logic [dqr_pkg::ADDR_W-1:0]  addr_ff;
   logic [dqr_pkg::STAMP_W-1:0] stamp_ff;
   dqr_pkg::pkt_type            pkt_ff;
   dqr_pkg::pkt_type            pkt_in_nx;
   logic                        live;
   logic                        hit_here;

   assign live = (up_ff != '0);

   // fold this slot into the passing packet
   always_comb begin
      pkt_in_nx = pkt_in;
      hit_here  = 1'b0;
      case (pkt_in.mode)
         dqr_pkg::MODE_QUERY: begin
            hit_here = live && (cid_ff == pkt_in.key_id) && (addr_ff == pkt_in.key_addr);
         end
         dqr_pkg::MODE_LOOKUP: begin
            hit_here = live && (up_ff == pkt_in.key_id);
         end
         default: begin
            hit_here = 1'b0;
         end
      endcase
      if (pkt_in.valid) begin
         // first match wins, its contents ride along
         if (!pkt_in.hit && hit_here) begin
            pkt_in_nx.hit      = 1'b1;
            pkt_in_nx.hit_idx  = MY_IDX;
            pkt_in_nx.hit_up   = up_ff;
            pkt_in_nx.hit_cid  = cid_ff;
            pkt_in_nx.hit_addr = addr_ff;
         end
         // candidate id already owned by a live slot
         if (live && (up_ff == pkt_in.cand)) begin
            pkt_in_nx.cand_used = 1'b1;
         end
         // first free slot, else oldest stamp not above now (last among equals)
         if (pkt_in.mode == dqr_pkg::MODE_QUERY && !pkt_in.free_found) begin
            if (!live) begin
               pkt_in_nx.free_found = 1'b1;
               pkt_in_nx.free_idx   = MY_IDX;
            end else if (stamp_ff <= pkt_in.old_time) begin
               pkt_in_nx.old_time = stamp_ff;
               pkt_in_nx.old_idx  = MY_IDX;
            end
         end
      end
   end

   // packet stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.valid <= 1'b0;
      end else begin
         pkt_ff.valid <= pkt_in_nx.valid;
      end
      pkt_ff.mode       <= pkt_in_nx.mode;
      pkt_ff.key_id     <= pkt_in_nx.key_id;
      pkt_ff.key_addr   <= pkt_in_nx.key_addr;
      pkt_ff.cand       <= pkt_in_nx.cand;
      pkt_ff.hit        <= pkt_in_nx.hit;
      pkt_ff.hit_idx    <= pkt_in_nx.hit_idx;
      pkt_ff.hit_up     <= pkt_in_nx.hit_up;
      pkt_ff.hit_cid    <= pkt_in_nx.hit_cid;
      pkt_ff.hit_addr   <= pkt_in_nx.hit_addr;
      pkt_ff.free_found <= pkt_in_nx.free_found;
      pkt_ff.free_idx   <= pkt_in_nx.free_idx;
      pkt_ff.old_idx    <= pkt_in_nx.old_idx;
      pkt_ff.old_time   <= pkt_in_nx.old_time;
      pkt_ff.cand_used  <= pkt_in_nx.cand_used;
   end

   assign pkt_out = pkt_ff;

   // slot contents; only the upstream id is cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= '0;
      end else if (wr.en && wr.idx == MY_IDX) begin
         up_ff <= wr.clear ? '0 : wr.up;
      end
      if (wr.en && !wr.clear && wr.idx == MY_IDX) begin
         cid_ff   <= wr.cid;
         addr_ff  <= wr.addr;
         stamp_ff <= wr.stamp;
      end
   end

endmodule

`default_nettype wire

### rtl/dqr_ctrl.sv
// dqr_ctrl: request sequencer, id generator, config register and result register
// depends on dqr_pkg; drives the head of the cell row and reads its tail
`default_nettype none

module dqr_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [15:0]                   req_packet_id,
   input  wire logic [47:0]                   req_client_addr,
   input  wire logic                          req_recursion_desired,
   input  wire logic [3:0]                    req_rcode,
   input  wire logic [31:0]                   req_now,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_upstream_present,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [15:0]                        rsp_upstream_id,
   output logic [15:0]                        rsp_client_id,
   output logic [47:0]                        rsp_client_addr_out,
   output logic [5:0]                         rsp_slot,
   output logic                               rsp_evicted,
   output dqr_pkg::pkt_type                   pkt_head,
   input  wire dqr_pkg::pkt_type              pkt_tail,
   output dqr_pkg::wr_type                    wr
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       act_ff, act_in;
   logic [15:0]                      pid_ff, pid_in;
   logic [47:0]                      addr_ff, addr_in;
   logic [3:0]                       rcode_ff, rcode_in;
   logic [31:0]                      now_ff, now_in;
   logic [15:0]                      cand_ff, cand_in;
   logic [15:0]                      lfsr_ff, lfsr_in;
   logic [dqr_pkg::IDX_W-1:0]        tgt_ff, tgt_in;
   logic                             evict_ff, evict_in;
   logic                             present_ff, present_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [2:0]                       rsp_status_ff, rsp_status_in;
   logic [15:0]                      rsp_up_ff, rsp_up_in;
   logic [15:0]                      rsp_cid_ff, rsp_cid_in;
   logic [47:0]                      rsp_addr_ff, rsp_addr_in;
   logic [5:0]                       rsp_slot_ff, rsp_slot_in;
   logic                             rsp_ev_ff, rsp_ev_in;
   logic                             commit_go;
   logic [dqr_pkg::IDX_W-1:0]        commit_idx;
   logic                             commit_ev;
   logic                             accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      pid_in        = pid_ff;
      addr_in       = addr_ff;
      rcode_in      = rcode_ff;
      now_in        = now_ff;
      cand_in       = cand_ff;
      lfsr_in       = lfsr_ff;
      tgt_in        = tgt_ff;
      evict_in      = evict_ff;
      present_in    = csr_valid ? csr_upstream_present : present_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_up_in     = rsp_up_ff;
      rsp_cid_in    = rsp_cid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ev_in     = rsp_ev_ff;
      commit_go     = 1'b0;
      commit_idx    = tgt_ff;
      commit_ev     = evict_ff;
      pkt_head      = '0;
      wr            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               pid_in   = req_packet_id;
               addr_in  = req_client_addr;
               rcode_in = req_rcode;
               now_in   = req_now;
               if (req_action == dqr_pkg::ACT_QUERY &&
                   (!req_recursion_desired || !present_ff)) begin
                  // answered empty, table untouched
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dqr_pkg::STAT_EMPTY;
                  rsp_up_in     = '0;
                  rsp_cid_in    = req_packet_id;
                  rsp_addr_in   = req_client_addr;
                  rsp_slot_in   = '0;
                  rsp_ev_in     = 1'b0;
               end else if (req_action == dqr_pkg::ACT_QUERY) begin
                  // full query pass, first candidate id checked on the way
                  pkt_head.valid    = 1'b1;
                  pkt_head.mode     = dqr_pkg::MODE_QUERY;
                  pkt_head.key_id   = req_packet_id;
                  pkt_head.key_addr = req_client_addr;
                  pkt_head.cand     = dqr_pkg::lfsr_step(lfsr_ff);
                  pkt_head.old_time = req_now;
                  cand_in           = dqr_pkg::lfsr_step(lfsr_ff);
                  state_in          = ST_SCAN;
               end else if (req_action == dqr_pkg::ACT_REPLY ||
                            req_action == dqr_pkg::ACT_CANCEL) begin
                  pkt_head.valid  = 1'b1;
                  pkt_head.mode   = dqr_pkg::MODE_LOOKUP;
                  pkt_head.key_id = req_packet_id;
                  state_in        = ST_SCAN;
               end else begin
                  // unused action
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dqr_pkg::STAT_NO_MATCH;
                  rsp_up_in     = '0;
                  rsp_cid_in    = '0;
                  rsp_addr_in   = '0;
                  rsp_slot_in   = '0;
                  rsp_ev_in     = 1'b0;
               end
            end
         end

         ST_SCAN: begin
            if (pkt_tail.valid) begin
               state_in = ST_IDLE;
               if (act_ff == dqr_pkg::ACT_QUERY) begin
                  if (pkt_tail.hit) begin
                     // retry of a live slot
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = dqr_pkg::STAT_RETRY;
                     rsp_up_in     = pkt_tail.hit_up;
                     rsp_cid_in    = pkt_tail.hit_cid;
                     rsp_addr_in   = pkt_tail.hit_addr;
                     rsp_slot_in   = pkt_tail.hit_idx[5:0];
                     rsp_ev_in     = 1'b0;
                  end else begin
                     commit_idx = pkt_tail.free_found ? pkt_tail.free_idx : pkt_tail.old_idx;
                     commit_ev  = !pkt_tail.free_found;
                     tgt_in     = commit_idx;
                     evict_in   = commit_ev;
                     if (!pkt_tail.cand_used) begin
                        commit_go = 1'b1;
                     end else begin
                        pkt_head.valid = 1'b1;
                        pkt_head.mode  = dqr_pkg::MODE_CAND;
                        pkt_head.cand  = dqr_pkg::lfsr_step(cand_ff);
                        cand_in        = dqr_pkg::lfsr_step(cand_ff);
                        state_in       = ST_CHECK;
                     end
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_ev_in    = 1'b0;
                  if (!pkt_tail.hit) begin
                     rsp_status_in = dqr_pkg::STAT_NO_MATCH;
                     rsp_up_in     = '0;
                     rsp_cid_in    = '0;
                     rsp_addr_in   = '0;
                     rsp_slot_in   = '0;
                  end else begin
                     rsp_up_in   = pkt_tail.hit_up;
                     rsp_cid_in  = pkt_tail.hit_cid;
                     rsp_addr_in = pkt_tail.hit_addr;
                     rsp_slot_in = pkt_tail.hit_idx[5:0];
                     if (act_ff == dqr_pkg::ACT_REPLY &&
                         (rcode_ff inside {dqr_pkg::RCODE_SERVFAIL, dqr_pkg::RCODE_NOTIMP,
                                           dqr_pkg::RCODE_REFUSED})) begin
                        rsp_status_in = dqr_pkg::STAT_RETRYABLE;
                     end else begin
                        // deliver or cancel: free the slot
                        rsp_status_in = (act_ff == dqr_pkg::ACT_REPLY) ?
                                        dqr_pkg::STAT_DELIVER : dqr_pkg::STAT_CANCELLED;
                        wr.en    = 1'b1;
                        wr.clear = 1'b1;
                        wr.idx   = pkt_tail.hit_idx;
                     end
                  end
               end
            end
         end

         ST_CHECK: begin
            if (pkt_tail.valid) begin
               if (!pkt_tail.cand_used) begin
                  commit_go = 1'b1;
               end else begin
                  pkt_head.valid = 1'b1;
                  pkt_head.mode  = dqr_pkg::MODE_CAND;
                  pkt_head.cand  = dqr_pkg::lfsr_step(cand_ff);
                  cand_in        = dqr_pkg::lfsr_step(cand_ff);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // take the chosen slot with the unused candidate id
      if (commit_go) begin
         state_in      = ST_IDLE;
         lfsr_in       = cand_ff;
         wr.en         = 1'b1;
         wr.clear      = 1'b0;
         wr.idx        = commit_idx;
         wr.up         = cand_ff;
         wr.cid        = pid_ff;
         wr.addr       = addr_ff;
         wr.stamp      = now_ff;
         rsp_valid_in  = 1'b1;
         rsp_status_in = dqr_pkg::STAT_NEW;
         rsp_up_in     = cand_ff;
         rsp_cid_in    = pid_ff;
         rsp_addr_in   = addr_ff;
         rsp_slot_in   = commit_idx[5:0];
         rsp_ev_in     = commit_ev;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lfsr_ff      <= dqr_pkg::LFSR_SEED;
         present_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lfsr_ff      <= lfsr_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pid_ff        <= pid_in;
      addr_ff       <= addr_in;
      rcode_ff      <= rcode_in;
      now_ff        <= now_in;
      cand_ff       <= cand_in;
      tgt_ff        <= tgt_in;
      evict_ff      <= evict_in;
      rsp_status_ff <= rsp_status_in;
      rsp_up_ff     <= rsp_up_in;
      rsp_cid_ff    <= rsp_cid_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ev_ff     <= rsp_ev_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_upstream_id     = rsp_up_ff;
   assign rsp_client_id       = rsp_cid_ff;
   assign rsp_client_addr_out = rsp_addr_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_evicted         = rsp_ev_ff;

`ifndef ASSERT_OFF
   // a result only follows an accepted request or a finished pass
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(busy)))
      else $error("result without a request in progress");

   // the tail of the row only carries a packet while a pass is pending
   a_tail_state: assert property (@(posedge clock) disable iff (reset)
      pkt_tail.valid |-> (state_ff == ST_SCAN || state_ff == ST_CHECK))
      else $error("search packet out of the row while idle");

   // slot writes happen only when a pass has finished
   a_wr_tail: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> pkt_tail.valid)
      else $error("slot write without a finished pass");

   // a new slot never gets the free marker as its id
   a_new_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == dqr_pkg::STAT_NEW) |-> (rsp_up_ff != '0))
      else $error("new slot given id zero");

   // id generator never locks up at zero
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("id generator reached zero");
`endif

endmodule

`default_nettype wire
